// ----- rtl/tlp_pkg.sv -----
// Shared constants, control word and status types, and the microcode ROM of the tape processor.
package tlp_pkg;

	localparam int PROG_DEPTH = 4096;
	localparam int PROG_AW    = $clog2(PROG_DEPTH);
	localparam int TAPE_DEPTH = 1024;
	localparam int TAPE_AW    = $clog2(TAPE_DEPTH);
	localparam int LEN_W      = 13;
	localparam int ADDR_W     = 12;
	localparam int BYTE_W     = 8;
	localparam int OP_W       = 2;
	localparam int STEP_W     = 4;
	localparam int COND_W     = 4;

	// item operations
	localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
	localparam logic [OP_W-1:0] OP_STEP    = 2'd1;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

	// program characters
	localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h3E;
	localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h3C;
	localparam logic [BYTE_W-1:0] CH_INC   = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_DEC   = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_OUT   = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_IN    = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
	localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;

	// jump conditions
	localparam logic [COND_W-1:0] C_NEVER     = 4'd0;
	localparam logic [COND_W-1:0] C_ALWAYS    = 4'd1;
	localparam logic [COND_W-1:0] C_ITEM      = 4'd2;
	localparam logic [COND_W-1:0] C_OUT_FREE  = 4'd3;
	localparam logic [COND_W-1:0] C_CLR_MORE  = 4'd4;
	localparam logic [COND_W-1:0] C_BOOT      = 4'd5;
	localparam logic [COND_W-1:0] C_FWD       = 4'd6;
	localparam logic [COND_W-1:0] C_NBWD      = 4'd7;
	localparam logic [COND_W-1:0] C_J_END     = 4'd8;
	localparam logic [COND_W-1:0] C_J_ZERO    = 4'd9;
	localparam logic [COND_W-1:0] C_F_NOMATCH = 4'd10;
	localparam logic [COND_W-1:0] C_B_NOMATCH = 4'd11;

	// microprogram addresses
	localparam logic [STEP_W-1:0] U_BOOT  = 4'd0;
	localparam logic [STEP_W-1:0] U_CLR   = 4'd1;
	localparam logic [STEP_W-1:0] U_CLRE  = 4'd2;
	localparam logic [STEP_W-1:0] U_DONE  = 4'd3;
	localparam logic [STEP_W-1:0] U_IDLE  = 4'd4;
	localparam logic [STEP_W-1:0] U_LOAD  = 4'd5;
	localparam logic [STEP_W-1:0] U_FETCH = 4'd6;
	localparam logic [STEP_W-1:0] U_EXEC  = 4'd7;
	localparam logic [STEP_W-1:0] U_EXEC2 = 4'd8;
	localparam logic [STEP_W-1:0] U_BRD   = 4'd9;
	localparam logic [STEP_W-1:0] U_BCHK  = 4'd10;
	localparam logic [STEP_W-1:0] U_BOUT  = 4'd11;
	localparam logic [STEP_W-1:0] U_FRD   = 4'd12;
	localparam logic [STEP_W-1:0] U_FCHK  = 4'd13;
	localparam logic [STEP_W-1:0] U_FOUT  = 4'd14;
	localparam logic [STEP_W-1:0] U_ERR   = 4'd15;

	typedef struct packed {
		logic [COND_W-1:0] cond;
		logic [STEP_W-1:0] target;
		logic              dispatch;
		logic              hold;
		logic              in_ready;
		logic              clr_run;
		logic              clr_wr;
		logic              boot_clr;
		logic              out_load;
		logic              prog_wr;
		logic              prd_pc;
		logic              prd_j;
		logic              tape_rd;
		logic              exec;
		logic              fscan;
		logic              bscan_rd;
		logic              bscan;
		logic              set_err;
	} tlp_ctl_t;

	typedef struct packed {
		logic            item;
		logic [OP_W-1:0] op;
		logic            halted;
		logic            out_free;
		logic            clr_more;
		logic            boot;
		logic            fwd_go;
		logic            bwd_go;
		logic            j_end;
		logic            j_zero;
		logic            f_match;
		logic            b_match;
	} tlp_stat_t;

	typedef struct packed {
		logic              out_valid;
		logic [BYTE_W-1:0] out_byte;
		logic              halted;
		logic              bracket_error;
		logic [LEN_W-1:0]  position;
	} tlp_res_t;

	function automatic tlp_ctl_t ucode(input logic [STEP_W-1:0] step);
		tlp_ctl_t c;
		c = '0;
		case (step)
			U_BOOT: begin
				c.clr_run = 1'b1;
				c.cond    = C_NEVER;
			end
			U_CLR: begin
				c.clr_wr = 1'b1;
				c.cond   = C_CLR_MORE;
				c.target = U_CLR;
			end
			U_CLRE: begin
				c.boot_clr = 1'b1;
				c.cond     = C_BOOT;
				c.target   = U_IDLE;
			end
			U_DONE: begin
				c.out_load = 1'b1;
				c.hold     = 1'b1;
				c.cond     = C_OUT_FREE;
				c.target   = U_IDLE;
			end
			U_IDLE: begin
				c.in_ready = 1'b1;
				c.hold     = 1'b1;
				c.dispatch = 1'b1;
				c.cond     = C_ITEM;
			end
			U_LOAD: begin
				c.prog_wr = 1'b1;
				c.cond    = C_ALWAYS;
				c.target  = U_DONE;
			end
			U_FETCH: begin
				c.prd_pc  = 1'b1;
				c.tape_rd = 1'b1;
				c.cond    = C_NEVER;
			end
			U_EXEC: begin
				c.exec   = 1'b1;
				c.cond   = C_FWD;
				c.target = U_FRD;
			end
			U_EXEC2: begin
				c.cond   = C_NBWD;
				c.target = U_DONE;
			end
			U_BRD: begin
				c.bscan_rd = 1'b1;
				c.cond     = C_J_ZERO;
				c.target   = U_ERR;
			end
			U_BCHK: begin
				c.bscan  = 1'b1;
				c.cond   = C_B_NOMATCH;
				c.target = U_BRD;
			end
			U_BOUT: begin
				c.cond   = C_ALWAYS;
				c.target = U_DONE;
			end
			U_FRD: begin
				c.prd_j  = 1'b1;
				c.cond   = C_J_END;
				c.target = U_ERR;
			end
			U_FCHK: begin
				c.fscan  = 1'b1;
				c.cond   = C_F_NOMATCH;
				c.target = U_FRD;
			end
			U_FOUT: begin
				c.cond   = C_ALWAYS;
				c.target = U_DONE;
			end
			U_ERR: begin
				c.set_err = 1'b1;
				c.cond    = C_ALWAYS;
				c.target  = U_DONE;
			end
			default: begin
				c.cond   = C_ALWAYS;
				c.target = U_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/tlp_seq.sv -----
// Microcode sequencer: step counter, control ROM, condition select and jumps.
module tlp_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  tlp_pkg::tlp_stat_t stat,
	output tlp_pkg::tlp_ctl_t  ctl
);
	import tlp_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;
	logic [STEP_W-1:0] disp_tgt;
	logic              take;

	always_comb begin
		ctl = ucode(step_q);
	end

	always_comb begin
		case (ctl.cond)
			C_NEVER:     take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_ITEM:      take = stat.item;
			C_OUT_FREE:  take = stat.out_free;
			C_CLR_MORE:  take = stat.clr_more;
			C_BOOT:      take = stat.boot;
			C_FWD:       take = stat.fwd_go;
			C_NBWD:      take = !stat.bwd_go;
			C_J_END:     take = stat.j_end;
			C_J_ZERO:    take = stat.j_zero;
			C_F_NOMATCH: take = !stat.f_match;
			C_B_NOMATCH: take = !stat.b_match;
			default:     take = 1'b0;
		endcase
	end

	// entry point of each item kind
	always_comb begin
		case (stat.op)
			OP_LOAD:    disp_tgt = U_LOAD;
			OP_STEP:    disp_tgt = stat.halted ? U_DONE : U_FETCH;
			OP_RESTART: disp_tgt = U_BOOT;
			default:    disp_tgt = U_DONE;
		endcase
	end

	always_comb begin
		if (take) begin
			step_d = ctl.dispatch ? disp_tgt : ctl.target;
		end else if (ctl.hold) begin
			step_d = step_q;
		end else begin
			step_d = STEP_W'(step_q + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= U_BOOT;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

// ----- rtl/tlp_dp.sv -----
// Datapath: program and tape memories, run registers and scan counters.
module tlp_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tlp_pkg::tlp_ctl_t           ctl,
	input  logic                        cfg_take,
	input  logic [tlp_pkg::LEN_W-1:0]   cfg_len,
	input  logic                        in_take,
	input  logic                        out_free,
	input  logic [tlp_pkg::OP_W-1:0]    op,
	input  logic [tlp_pkg::ADDR_W-1:0]  load_address,
	input  logic [tlp_pkg::BYTE_W-1:0]  program_byte,
	input  logic [tlp_pkg::BYTE_W-1:0]  input_byte,
	output tlp_pkg::tlp_stat_t          stat,
	output tlp_pkg::tlp_res_t           res
);
	import tlp_pkg::*;

	logic [BYTE_W-1:0] prog_mem [PROG_DEPTH];
	logic [BYTE_W-1:0] tape_mem [TAPE_DEPTH];

	// run state
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   pc_q;
	logic [TAPE_AW-1:0] ptr_q;
	logic [LEN_W-1:0]   j_q;
	logic [LEN_W-1:0]   depth_q;
	logic               err_q;
	logic               boot_q;
	logic               emit_q;

	// item payload and memory read data
	logic [PROG_AW-1:0] addr_q;
	logic [BYTE_W-1:0]  pbyte_q;
	logic [BYTE_W-1:0]  ibyte_q;
	logic [BYTE_W-1:0]  emit_byte_q;
	logic [BYTE_W-1:0]  prd_q;
	logic [BYTE_W-1:0]  trd_q;

	logic [LEN_W-1:0]   eff_len;
	logic [LEN_W-1:0]   jm1;
	logic [PROG_AW-1:0] prd_addr;
	logic               prd_en;
	logic               tape_we;
	logic [TAPE_AW-1:0] tape_waddr;
	logic [BYTE_W-1:0]  tape_wdata;
	logic               halted;
	logic               fwd_go;
	logic               bwd_go;
	logic               f_match;
	logic               b_match;

	assign eff_len = (len_q > LEN_W'(PROG_DEPTH)) ? LEN_W'(PROG_DEPTH) : len_q;
	assign jm1     = j_q - 1'b1;
	assign halted  = err_q || (pc_q >= eff_len);
	assign fwd_go  = (prd_q == CH_OPEN) && (trd_q == '0);
	assign bwd_go  = (prd_q == CH_CLOSE) && (trd_q != '0);
	assign f_match = (prd_q == CH_CLOSE) && (depth_q == LEN_W'(1));
	assign b_match = (prd_q == CH_OPEN) && (depth_q == LEN_W'(1));

	always_comb begin
		stat          = '0;
		stat.item     = in_take;
		stat.op       = op;
		stat.halted   = halted;
		stat.out_free = out_free;
		stat.clr_more = (j_q[TAPE_AW-1:0] != '1);
		stat.boot     = boot_q;
		stat.fwd_go   = fwd_go;
		stat.bwd_go   = bwd_go;
		stat.j_end    = (j_q >= eff_len);
		stat.j_zero   = (j_q == '0);
		stat.f_match  = f_match;
		stat.b_match  = b_match;
	end

	always_comb begin
		res               = '0;
		res.out_valid     = emit_q;
		res.out_byte      = emit_q ? emit_byte_q : '0;
		res.halted        = halted;
		res.bracket_error = err_q;
		res.position      = pc_q;
	end

	// program memory: one write port, one registered read port
	always_comb begin
		prd_en = ctl.prd_pc || ctl.prd_j || ctl.bscan_rd;
		if (ctl.prd_pc) begin
			prd_addr = pc_q[PROG_AW-1:0];
		end else if (ctl.bscan_rd) begin
			prd_addr = jm1[PROG_AW-1:0];
		end else begin
			prd_addr = j_q[PROG_AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.prog_wr) begin
			prog_mem[addr_q] <= pbyte_q;
		end
		if (prd_en) begin
			prd_q <= prog_mem[prd_addr];
		end
	end

	// tape memory: clear sweep or cell update
	always_comb begin
		tape_we    = 1'b0;
		tape_waddr = ptr_q;
		tape_wdata = trd_q;
		if (ctl.clr_wr) begin
			tape_we    = 1'b1;
			tape_waddr = j_q[TAPE_AW-1:0];
			tape_wdata = '0;
		end else if (ctl.exec) begin
			case (prd_q)
				CH_INC: begin
					tape_we    = 1'b1;
					tape_wdata = trd_q + 1'b1;
				end
				CH_DEC: begin
					tape_we    = 1'b1;
					tape_wdata = trd_q - 1'b1;
				end
				CH_IN: begin
					tape_we    = 1'b1;
					tape_wdata = ibyte_q;
				end
				default: tape_we = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tape_we) begin
			tape_mem[tape_waddr] <= tape_wdata;
		end
		if (ctl.tape_rd) begin
			trd_q <= tape_mem[ptr_q];
		end
	end

	// latch the item payload on transfer
	always_ff @(posedge clk) begin
		if (in_take) begin
			addr_q  <= PROG_AW'(load_address);
			pbyte_q <= program_byte;
			ibyte_q <= input_byte;
		end
		if (ctl.exec && prd_q == CH_OUT) begin
			emit_byte_q <= trd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			pc_q    <= '0;
			ptr_q   <= '0;
			j_q     <= '0;
			depth_q <= '0;
			err_q   <= 1'b0;
			boot_q  <= 1'b1;
			emit_q  <= 1'b0;
		end else begin
			if (cfg_take) begin
				len_q <= cfg_len;
			end
			if (in_take) begin
				emit_q <= 1'b0;
			end
			if (ctl.boot_clr) begin
				boot_q <= 1'b0;
			end
			if (ctl.clr_run) begin
				pc_q    <= '0;
				ptr_q   <= '0;
				j_q     <= '0;
				depth_q <= '0;
				err_q   <= 1'b0;
			end
			if (ctl.clr_wr) begin
				j_q <= j_q + 1'b1;
			end
			if (ctl.exec) begin
				case (prd_q)
					CH_RIGHT: ptr_q  <= ptr_q + 1'b1;
					CH_LEFT:  ptr_q  <= ptr_q - 1'b1;
					CH_OUT:   emit_q <= 1'b1;
					default:  ptr_q  <= ptr_q;
				endcase
				if (fwd_go) begin
					j_q     <= pc_q + 1'b1;
					depth_q <= LEN_W'(1);
				end else if (bwd_go) begin
					j_q     <= pc_q;
					depth_q <= LEN_W'(1);
				end else begin
					pc_q <= pc_q + 1'b1;
				end
			end
			if (ctl.fscan) begin
				j_q <= j_q + 1'b1;
				if (prd_q == CH_OPEN) begin
					depth_q <= depth_q + 1'b1;
				end else if (prd_q == CH_CLOSE) begin
					depth_q <= depth_q - 1'b1;
				end
				if (f_match) begin
					pc_q <= j_q + 1'b1;
				end
			end
			if (ctl.bscan_rd) begin
				j_q <= jm1;
			end
			if (ctl.bscan) begin
				if (prd_q == CH_CLOSE) begin
					depth_q <= depth_q + 1'b1;
				end else if (prd_q == CH_OPEN) begin
					depth_q <= depth_q - 1'b1;
				end
				if (b_match) begin
					pc_q <= j_q + 1'b1;
				end
			end
			if (ctl.set_err) begin
				err_q   <= 1'b1;
				depth_q <= '0;
			end
		end
	end

endmodule

// ----- rtl/tape_language_processor.sv -----
// Top level of the tape language processor: handshakes, result register and sequencer/datapath.
// Interpreter for the eight-command tape language. Each input transfer carries one item:
// op 0 writes program_byte to the program store at load_address, op 1 runs one command at
// the program counter, op 2 clears the tape and zeroes the counter, pointer and error flag,
// op 3 only reports status. Every item returns exactly one result transfer carrying the
// status after the item. Control is a sixteen-word microprogram: a step counter walks a
// control ROM and a small datapath with one registered read port on each memory does the
// work. A restart clears the tape one cell per cycle; a bracket jump scans the program
// bytes one at a time for its match, and a scan that finds no match sets the error flag.
// After reset the block runs a clearing pass (the restart sequence without its result
// step) before it accepts the first item; the program_length register is writable at
// any time it is idle, including during that pass. The next item is accepted while a
// finished result still waits on the result channel; the block only stalls at the end of
// an item if the previous result has not yet been taken.
module tape_language_processor (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tlp_pkg::LEN_W-1:0]   program_length,
	// item channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tlp_pkg::OP_W-1:0]    op,
	input  logic [tlp_pkg::ADDR_W-1:0]  load_address,
	input  logic [tlp_pkg::BYTE_W-1:0]  program_byte,
	input  logic [tlp_pkg::BYTE_W-1:0]  input_byte,
	// result channel
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic                        out_valid,
	output logic [tlp_pkg::BYTE_W-1:0]  out_byte,
	output logic                        halted,
	output logic                        bracket_error,
	output logic [tlp_pkg::LEN_W-1:0]   program_position
);
	import tlp_pkg::*;

	tlp_ctl_t  ctl;
	tlp_stat_t stat;
	tlp_res_t  res;
	tlp_res_t  res_q;
	logic      res_valid_q;
	logic      in_take;
	logic      cfg_take;
	logic      out_free;
	logic      res_load;

	// The length register takes a write in any cycle.
	assign cfg_ready = 1'b1;
	assign cfg_take  = cfg_valid && cfg_ready;

	// Accept an item only in the idle step of the microprogram.
	assign in_ready = ctl.in_ready;
	assign in_take  = in_valid && in_ready;

	// The result register is free when empty or when its content transfers this cycle.
	assign out_free = !res_valid_q || result_ready;
	assign res_load = ctl.out_load && out_free;

	tlp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	tlp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.cfg_take     (cfg_take),
		.cfg_len      (program_length),
		.in_take      (in_take),
		.out_free     (out_free),
		.op           (op),
		.load_address (load_address),
		.program_byte (program_byte),
		.input_byte   (input_byte),
		.stat         (stat),
		.res          (res)
	);

	// Hold the result until the consumer takes it; load a new one at the end of an item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign result_valid     = res_valid_q;
	assign out_valid        = res_q.out_valid;
	assign out_byte         = res_q.out_byte;
	assign halted           = res_q.halted;
	assign bracket_error    = res_q.bracket_error;
	assign program_position = res_q.position;

endmodule
